FILE: src/packet_burst_rate_detector_core_assert.svh
// ----------------------------------------------------------------------------
// Packet burst rate detector assertion macros
// Concurrent assertion wrappers clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef PACKET_BURST_RATE_DETECTOR_CORE_ASSERT_SVH
`define PACKET_BURST_RATE_DETECTOR_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check prop at every clock edge outside reset.
`define PBRD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check prop at every clock edge, reset included.
`define PBRD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PBRD_ASSERT(label, prop, msg)
`define PBRD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: src/pbrd_pkg.sv
// ----------------------------------------------------------------------------
// Packet burst rate detector package
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package pbrd_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int COUNT_W_MAX    = 32;
  localparam int TIME_W         = 64;
  localparam int INTERVAL_W     = 36;
  localparam int THRESH_W       = 32;
  localparam int RATE_W         = 62;
  localparam int SEV_W          = 2;
  localparam int NS_W           = 30;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 36;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [NS_W-1:0] NS_PER_SEC = NS_W'(1000000000);

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_THR_LOW   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_THR_MED   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_THR_HIGH  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_THR_CRIT  = 3'd4;

  // Reset values
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = INTERVAL_W'(1000000000);
  localparam logic [THRESH_W-1:0]   THR_LOW_RST  = THRESH_W'(1000);
  localparam logic [THRESH_W-1:0]   THR_MED_RST  = THRESH_W'(10000);
  localparam logic [THRESH_W-1:0]   THR_HIGH_RST = THRESH_W'(50000);
  localparam logic [THRESH_W-1:0]   THR_CRIT_RST = THRESH_W'(100000);

  // Severity codes
  localparam logic [SEV_W-1:0] SEV_LOW  = 2'd0;
  localparam logic [SEV_W-1:0] SEV_MED  = 2'd1;
  localparam logic [SEV_W-1:0] SEV_HIGH = 2'd2;
  localparam logic [SEV_W-1:0] SEV_CRIT = 2'd3;

  typedef logic [TIME_W-1:0]      time_t;
  typedef logic [COUNT_W_MAX-1:0] count_t;
  typedef logic [RATE_W-1:0]      rate_t;

  // One closed interval, handed from front to back
  typedef struct packed {
    time_t  event_time;
    count_t count;
    time_t  elapsed;
  } job_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

  typedef struct packed {
    logic [THRESH_W-1:0] low;
    logic [THRESH_W-1:0] med;
    logic [THRESH_W-1:0] high;
    logic [THRESH_W-1:0] critical;
  } thresh_t;

endpackage

FILE: src/pbrd_front.sv
// ----------------------------------------------------------------------------
// Packet burst rate detector front end
// Counts packets, measures elapsed time and closes intervals into the queue.
// ----------------------------------------------------------------------------
module pbrd_front #(
  parameter int COUNT_BITS = pbrd_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  pbrd_pkg::time_t                  in_time,
  input  logic [pbrd_pkg::INTERVAL_W-1:0]  interval,
  input  pbrd_pkg::q_stat_t                q_stat,
  output logic                             push,
  output pbrd_pkg::job_t                   job
);

  logic [COUNT_BITS-1:0]               count_r, count_nxt, count_inc;
  pbrd_pkg::time_t                     check_time_r, check_time_nxt;
  pbrd_pkg::time_t                     elapsed;
  logic [pbrd_pkg::INTERVAL_W-1:0]     limit;
  logic                                accept, check;

  assign in_ready  = !q_stat.full;
  assign accept    = in_valid && in_ready;
  // Saturate at all ones
  assign count_inc = (count_r == '1) ? count_r : count_r + 1'b1;
  assign elapsed   = in_time - check_time_r;
  // A zero interval acts as one nanosecond
  assign limit     = (interval == '0) ? pbrd_pkg::INTERVAL_W'(1) : interval;
  assign check     = elapsed >= pbrd_pkg::time_t'(limit);
  assign push      = accept && check;

  assign job.event_time = in_time;
  assign job.count      = pbrd_pkg::count_t'(count_inc);
  assign job.elapsed    = elapsed;

  always_comb begin
    count_nxt      = count_r;
    check_time_nxt = check_time_r;
    if (accept) begin
      if (check) begin
        count_nxt      = '0;
        check_time_nxt = in_time;
      end else begin
        count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      check_time_r <= '0;
    end else begin
      count_r      <= count_nxt;
      check_time_r <= check_time_nxt;
    end
  end

endmodule

FILE: src/pbrd_queue.sv
// ----------------------------------------------------------------------------
// Packet burst rate detector job queue
// Short FIFO of closed intervals between front end and divider back end.
// ----------------------------------------------------------------------------
module pbrd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pbrd_pkg::job_t    push_job,
  input  logic              pop,
  output pbrd_pkg::job_t    head_job,
  output pbrd_pkg::q_stat_t q_stat
);

  localparam int PTR_W = (pbrd_pkg::QUEUE_DEPTH > 1) ? $clog2(pbrd_pkg::QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(pbrd_pkg::QUEUE_DEPTH - 1);
  localparam logic [PTR_W:0]   FULL_CNT = (PTR_W + 1)'(pbrd_pkg::QUEUE_DEPTH);

  pbrd_pkg::job_t   entry_r [pbrd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign q_stat.full     = (cnt_r == FULL_CNT);
  assign q_stat.nonempty = (cnt_r != '0);
  assign head_job        = entry_r[rd_ptr_r];
  assign do_push         = push && !q_stat.full;
  assign do_pop          = pop && q_stat.nonempty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: src/pbrd_back.sv
// ----------------------------------------------------------------------------
// Packet burst rate detector back end
// Multiplies, divides one quotient bit a cycle, grades and registers events.
// ----------------------------------------------------------------------------
module pbrd_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            job_valid,
  input  pbrd_pkg::job_t                  job,
  output logic                            pop,
  input  pbrd_pkg::thresh_t               thresh,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pbrd_pkg::time_t                 out_time,
  output pbrd_pkg::rate_t                 out_rate,
  output logic [pbrd_pkg::SEV_W-1:0]      out_sev
);

  localparam int STEP_W = $clog2(pbrd_pkg::RATE_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(pbrd_pkg::RATE_W - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MUL   = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_GRADE = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [STEP_W-1:0]            step_r, step_nxt;
  pbrd_pkg::time_t              time_r;
  pbrd_pkg::time_t              div_r;
  pbrd_pkg::count_t             cnt_r;
  pbrd_pkg::time_t              rem_r;
  pbrd_pkg::rate_t              quo_r;
  pbrd_pkg::rate_t              prod;
  logic [pbrd_pkg::TIME_W:0]    rem_shift, rem_diff;
  logic                         q_bit;
  logic                         burst;
  logic [pbrd_pkg::SEV_W-1:0]   sev;
  logic                         out_free, load_out;
  logic                         out_valid_r, out_valid_nxt;
  pbrd_pkg::time_t              out_time_r;
  pbrd_pkg::rate_t              out_rate_r;
  logic [pbrd_pkg::SEV_W-1:0]   out_sev_r;

  assign prod      = cnt_r * pbrd_pkg::NS_PER_SEC;
  assign rem_shift = {rem_r, quo_r[pbrd_pkg::RATE_W-1]};
  assign rem_diff  = rem_shift - {1'b0, div_r};
  assign q_bit     = rem_shift >= {1'b0, div_r};

  always_comb begin
    burst = 1'b1;
    sev   = pbrd_pkg::SEV_LOW;
    priority if (quo_r >= pbrd_pkg::rate_t'(thresh.critical)) begin
      sev = pbrd_pkg::SEV_CRIT;
    end else if (quo_r >= pbrd_pkg::rate_t'(thresh.high)) begin
      sev = pbrd_pkg::SEV_HIGH;
    end else if (quo_r >= pbrd_pkg::rate_t'(thresh.med)) begin
      sev = pbrd_pkg::SEV_MED;
    end else if (quo_r >= pbrd_pkg::rate_t'(thresh.low)) begin
      sev = pbrd_pkg::SEV_LOW;
    end else begin
      burst = 1'b0;
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign pop      = (state_r == ST_IDLE) && job_valid;
  assign load_out = (state_r == ST_GRADE) && burst && out_free;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_GRADE;
        end
      end
      ST_GRADE: begin
        // Drop quiet intervals; hold a burst until the output slot frees
        if (!burst) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      time_r <= job.event_time;
      div_r  <= job.elapsed;
      cnt_r  <= job.count;
    end
    if (state_r == ST_MUL) begin
      quo_r <= prod;
      rem_r <= '0;
    end else if (state_r == ST_DIV) begin
      quo_r <= {quo_r[pbrd_pkg::RATE_W-2:0], q_bit};
      rem_r <= q_bit ? rem_diff[pbrd_pkg::TIME_W-1:0] : rem_shift[pbrd_pkg::TIME_W-1:0];
    end
    if (load_out) begin
      out_time_r <= time_r;
      out_rate_r <= quo_r;
      out_sev_r  <= sev;
    end
  end

  assign out_valid = out_valid_r;
  assign out_time  = out_time_r;
  assign out_rate  = out_rate_r;
  assign out_sev   = out_sev_r;

endmodule

FILE: src/packet_burst_rate_detector_core.sv
// ----------------------------------------------------------------------------
// Packet burst rate detector core
// Flags packet bursts by rate over a configurable interval.
// ----------------------------------------------------------------------------
// Every input beat is one packet arrival with a 64-bit nanosecond timestamp.
// The front end takes one beat per clock: it bumps a saturating packet count
// (current packet included) and, once the arrival is at least interval_ns
// past the last check (modulo 2^64, a zero interval acting as one), closes
// the interval, clears the count and pushes the count, timestamp and elapsed
// time into a two-entry queue. The back end turns each closed interval into
// a rate: it loads the job, does the count * 1e9 multiply, runs the
// bit-serial restoring divide and grades the quotient against the four
// thresholds. Only a rate at or above threshold_low produces an output beat,
// carrying timestamp, rate and severity; an output register holds it while
// the back end takes the next job. in_tready drops only while two closed
// intervals are pending, so the sustained rate is one packet per cycle as
// long as intervals close no faster than the back end can grade them.
// Write configuration only while the core is idle.
// ----------------------------------------------------------------------------
`include "packet_burst_rate_detector_core_assert.svh"

module packet_burst_rate_detector_core #(
  parameter int COUNT_BITS = pbrd_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: [63:0] arrival_time_ns
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [63:0]                       in_tdata,
  // out_tdata: [63:0] event_time_ns, [125:64] rate_pps, [127:126] severity
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [127:0]                      out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [pbrd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [pbrd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [pbrd_pkg::INTERVAL_W-1:0] interval_r, interval_nxt;
  pbrd_pkg::thresh_t               thresh_r, thresh_nxt;

  logic                            push, pop;
  pbrd_pkg::job_t                  push_job, head_job;
  pbrd_pkg::q_stat_t               q_stat;
  pbrd_pkg::time_t                 out_time;
  pbrd_pkg::rate_t                 out_rate;
  logic [pbrd_pkg::SEV_W-1:0]      out_sev;

  // Configuration writes; unknown indexes are ignored
  always_comb begin
    interval_nxt = interval_r;
    thresh_nxt   = thresh_r;
    if (cfg_wr_en) begin
      unique case (cfg_addr)
        pbrd_pkg::REG_INTERVAL: interval_nxt = cfg_wdata[pbrd_pkg::INTERVAL_W-1:0];
        pbrd_pkg::REG_THR_LOW:  thresh_nxt.low = cfg_wdata[pbrd_pkg::THRESH_W-1:0];
        pbrd_pkg::REG_THR_MED:  thresh_nxt.med = cfg_wdata[pbrd_pkg::THRESH_W-1:0];
        pbrd_pkg::REG_THR_HIGH: thresh_nxt.high = cfg_wdata[pbrd_pkg::THRESH_W-1:0];
        pbrd_pkg::REG_THR_CRIT: thresh_nxt.critical = cfg_wdata[pbrd_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r        <= pbrd_pkg::INTERVAL_RST;
      thresh_r.low      <= pbrd_pkg::THR_LOW_RST;
      thresh_r.med      <= pbrd_pkg::THR_MED_RST;
      thresh_r.high     <= pbrd_pkg::THR_HIGH_RST;
      thresh_r.critical <= pbrd_pkg::THR_CRIT_RST;
    end else begin
      interval_r <= interval_nxt;
      thresh_r   <= thresh_nxt;
    end
  end

  // Front end: count packets and close intervals
  pbrd_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_time  (in_tdata),
    .interval (interval_r),
    .q_stat   (q_stat),
    .push     (push),
    .job      (push_job)
  );

  // Decouple the line-rate front from the slow divider
  pbrd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  // Back end: rate, grade and output beat
  pbrd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_stat.nonempty),
    .job       (head_job),
    .pop       (pop),
    .thresh    (thresh_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_time  (out_time),
    .out_rate  (out_rate),
    .out_sev   (out_sev)
  );

  assign out_tdata = {out_sev, out_rate, out_time};

  // Front never pushes into a full queue
  `PBRD_ASSERT(a_push_not_full, push |-> !q_stat.full, "interval closed into a full queue")
  // Back only pops a pending job
  `PBRD_ASSERT(a_pop_nonempty, pop |-> q_stat.nonempty, "job popped from an empty queue")
  // Every event carries a rate at or above the lowest threshold
  `PBRD_ASSERT(a_event_is_burst,
    out_tvalid |-> (out_tdata[125:64] >= pbrd_pkg::rate_t'(thresh_r.low)),
    "event below lowest threshold")
  // Reset leaves no event pending on the first cycle out of reset
  `PBRD_ASSERT_ALWAYS(a_reset_clears_out, (rst_n && $past(!rst_n)) |-> !out_tvalid,
    "event pending after reset")

endmodule

FILE: tb/sv/packet_burst_rate_detector_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet burst rate detector core testbench
// Streams packet arrival timestamps into the core under bursty input and a
// stalling output, predicts every burst beat from its own copy of the count,
// the check time and the registers, and compares each output beat in order.
// ----------------------------------------------------------------------------
module packet_burst_rate_detector_core_tb;

  // Up to three closed intervals can still be in flight in the queue and
  // back end once the last expected beat has shown up.
  localparam int          DRAIN_CYCLES = 300;
  localparam int          HOLD_CYCLES  = 600;
  localparam int          HOLD_AFTER   = 40;
  localparam int          RANDOM_ITEMS = 1030;
  localparam logic [63:0] NS_SEC       = 64'd1000000000;
  // Indexes past the last register; writes there must be ignored.
  localparam logic [pbrd_pkg::CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [pbrd_pkg::CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    pbrd_pkg::time_t            event_time;
    pbrd_pkg::rate_t            rate;
    logic [pbrd_pkg::SEV_W-1:0] severity;
  } burst_event_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [63:0]                     in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [127:0]                    out_tdata;
  logic                            cfg_wr_en = 1'b0;
  logic [pbrd_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [pbrd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  packet_burst_rate_detector_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: shadow registers and state of the core
  // --------------------------------------------------------------------------
  logic [pbrd_pkg::INTERVAL_W-1:0] sh_interval;
  logic [pbrd_pkg::THRESH_W-1:0]   sh_thr_low, sh_thr_med, sh_thr_high, sh_thr_crit;
  pbrd_pkg::count_t                shadow_count;
  pbrd_pkg::time_t                 shadow_check_time;

  pbrd_pkg::time_t arrival_q[$];     // timestamps waiting for the driver
  burst_event_t    burst_event_q[$]; // bursts predicted, not yet seen
  int              errors = 0;
  int              results_seen = 0;
  pbrd_pkg::time_t next_ts = '0;
  int              items_queued = 0;

  function automatic void shadow_reset();
    sh_interval       = pbrd_pkg::INTERVAL_RST;
    sh_thr_low        = pbrd_pkg::THR_LOW_RST;
    sh_thr_med        = pbrd_pkg::THR_MED_RST;
    sh_thr_high       = pbrd_pkg::THR_HIGH_RST;
    sh_thr_crit       = pbrd_pkg::THR_CRIT_RST;
    shadow_count      = '0;
    shadow_check_time = '0;
  endfunction

  // Thresholds keep only their low 32 bits; unknown indexes fall through.
  function automatic void shadow_write(logic [pbrd_pkg::CFG_ADDR_W-1:0] idx,
                                       logic [pbrd_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      pbrd_pkg::REG_INTERVAL: sh_interval = val;
      pbrd_pkg::REG_THR_LOW:  sh_thr_low  = val[pbrd_pkg::THRESH_W-1:0];
      pbrd_pkg::REG_THR_MED:  sh_thr_med  = val[pbrd_pkg::THRESH_W-1:0];
      pbrd_pkg::REG_THR_HIGH: sh_thr_high = val[pbrd_pkg::THRESH_W-1:0];
      pbrd_pkg::REG_THR_CRIT: sh_thr_crit = val[pbrd_pkg::THRESH_W-1:0];
      default: ;
    endcase
  endfunction

  // Bump the saturating count, close the interval once enough time has
  // passed (modulo 2^64, zero interval acting as one), grade the rate and
  // queue a burst beat if it clears the lowest threshold.
  function automatic void track_arrival(pbrd_pkg::time_t now);
    pbrd_pkg::time_t            elapsed;
    pbrd_pkg::time_t            limit;
    logic [63:0]                product;
    logic [63:0]                rate;
    logic [pbrd_pkg::SEV_W-1:0] sev;
    logic                       burst;
    burst_event_t               ev;
    if (shadow_count != '1) shadow_count = shadow_count + 1'b1;
    elapsed = now - shadow_check_time;
    limit   = (sh_interval == '0) ? 64'd1 : 64'(sh_interval);
    if (elapsed < limit) return;
    product = 64'(shadow_count) * NS_SEC;
    rate    = product / elapsed;
    burst   = 1'b1;
    sev     = pbrd_pkg::SEV_LOW;
    if (rate >= 64'(sh_thr_crit))      sev = pbrd_pkg::SEV_CRIT;
    else if (rate >= 64'(sh_thr_high)) sev = pbrd_pkg::SEV_HIGH;
    else if (rate >= 64'(sh_thr_med))  sev = pbrd_pkg::SEV_MED;
    else if (rate >= 64'(sh_thr_low))  sev = pbrd_pkg::SEV_LOW;
    else                               burst = 1'b0;
    shadow_count      = '0;
    shadow_check_time = now;
    if (burst) begin
      ev.event_time = now;
      ev.rate       = rate[pbrd_pkg::RATE_W-1:0];
      ev.severity   = sev;
      burst_event_q.push_back(ev);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: bursts of random length, random gaps, some bursts gapless
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      // Current beat is gone (or none was up): idle, advance or drop valid.
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (arrival_q.size() != 0) begin
        in_tdata  <= arrival_q.pop_front();
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output receiver: rotating stall pattern, reloaded now and then, plus one
  // long hold-off once enough bursts have come to back the core up
  // --------------------------------------------------------------------------
  logic [31:0] stall_pat = '1;
  int          pat_age   = 0;
  int          hold_cnt  = 0;
  logic        hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt   <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done  <= 1'b1;
      hold_cnt   <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (pat_age == 0) begin
      // About one pattern in three never stalls.
      stall_pat  <= ($urandom_range(0, 2) == 0) ? '1 : $urandom;
      pat_age    <= $urandom_range(16, 96);
      out_tready <= 1'b1;
    end else begin
      stall_pat  <= {stall_pat[0], stall_pat[31:1]};
      pat_age    <= pat_age - 1;
      out_tready <= stall_pat[0];
    end
  end

  // --------------------------------------------------------------------------
  // Scoreboard: predict on each input beat, check each output beat in order
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    burst_event_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) track_arrival(in_tdata);
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (burst_event_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected burst beat, actual %h", $time, out_tdata);
        end else begin
          want = burst_event_q.pop_front();
          if (out_tdata[63:0] !== want.event_time) begin
            errors++;
            $display("%0t: event_time_ns expected %0d actual %0d",
                     $time, want.event_time, out_tdata[63:0]);
          end
          if (out_tdata[125:64] !== want.rate) begin
            errors++;
            $display("%0t: rate_pps expected %0d actual %0d",
                     $time, want.rate, out_tdata[125:64]);
          end
          if (out_tdata[127:126] !== want.severity) begin
            errors++;
            $display("%0t: severity expected %0d actual %0d",
                     $time, want.severity, out_tdata[127:126]);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // One register write per clock; keep the enable high across a group and
  // drop it with end_writes.
  task automatic write_reg(logic [pbrd_pkg::CFG_ADDR_W-1:0] idx,
                           logic [pbrd_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    shadow_write(idx, val);
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic queue_arrival(pbrd_pkg::time_t ts);
    arrival_q.push_back(ts);
    items_queued++;
  endtask

  // Hold until every arrival is taken and every burst seen, then let the
  // back end finish jobs that grade below threshold_low. Sample on the
  // falling edge so driver updates have settled.
  task automatic wait_idle();
    @(negedge clk);
    while (arrival_q.size() != 0 || in_tvalid || burst_event_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One random phase: pick an arrival spacing, an interval and thresholds
  // centered on the rate that spacing gives, then stream arrivals jittered
  // around that spacing with some random timestamps mixed in.
  task automatic random_phase(int n_items);
    int unsigned                   mode;
    logic [63:0]                   spacing;
    logic [63:0]                   ivl;
    logic [63:0]                   centre;
    logic [pbrd_pkg::THRESH_W-1:0] thr[4];
    logic [pbrd_pkg::THRESH_W-1:0] tmp;
    int                            a, b;
    mode    = $urandom_range(0, 9);
    spacing = $urandom_range(1, 2000);
    if (mode < 6) begin
      ivl = spacing * $urandom_range(1, 12);
    end else if (mode == 6) begin
      ivl = '0;
    end else if (mode == 7) begin
      spacing = 64'h1_0000_0000 + $urandom;
      ivl     = 64'hF_FFFF_FFFF;
    end else begin
      ivl     = {$urandom_range(0, 15), $urandom};
      spacing = ivl / $urandom_range(1, 10) + 1;
    end
    centre = NS_SEC / spacing;
    if ($urandom_range(0, 3) == 0) begin
      for (a = 0; a < 4; a++) thr[a] = $urandom;
    end else begin
      for (a = 0; a < 4; a++)
        thr[a] = pbrd_pkg::THRESH_W'(centre / 4 + ({32'b0, $urandom} % (2 * centre + 1)));
      for (a = 0; a < 3; a++)
        for (b = 0; b < 3 - a; b++)
          if (thr[b] > thr[b+1]) begin
            tmp = thr[b]; thr[b] = thr[b+1]; thr[b+1] = tmp;
          end
      if ($urandom_range(0, 4) == 0) thr[0] = '0;
    end
    write_reg(pbrd_pkg::REG_INTERVAL, ivl[pbrd_pkg::INTERVAL_W-1:0]);
    // Junk in the top nibble must be masked off by the threshold registers.
    write_reg(pbrd_pkg::REG_THR_LOW,  {4'($urandom_range(0, 15)), thr[0]});
    write_reg(pbrd_pkg::REG_THR_MED,  {4'($urandom_range(0, 15)), thr[1]});
    write_reg(pbrd_pkg::REG_THR_HIGH, {4'($urandom_range(0, 15)), thr[2]});
    write_reg(pbrd_pkg::REG_THR_CRIT, {4'($urandom_range(0, 15)), thr[3]});
    if ($urandom_range(0, 4) == 0)
      write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), {4'hF, $urandom});
    end_writes();
    // Sometimes start just short of the 64-bit wrap.
    if ($urandom_range(0, 5) == 0) next_ts = '1 - 64'($urandom_range(0, 100000));
    for (a = 0; a < n_items; a++) begin
      if (mode == 9 || $urandom_range(0, 19) == 0) begin
        queue_arrival({$urandom, $urandom});
      end else begin
        next_ts = next_ts + (spacing * $urandom_range(0, 200)) / 100;
        queue_arrival(next_ts);
      end
    end
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [pbrd_pkg::CFG_ADDR_W-1:0] idx;
    pbrd_pkg::time_t                 t0;
    shadow_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: one-second interval, far too slow to see a burst.
    queue_arrival(64'd0);
    queue_arrival(64'd1000000000);
    wait_idle();

    // Short interval, default thresholds: single-packet intervals walk
    // through every severity and the no-burst case.
    write_reg(pbrd_pkg::REG_INTERVAL, 36'd1000);
    end_writes();
    queue_arrival(64'd500);       // earlier than last check: huge elapsed, no beat
    queue_arrival(64'd5000);      // critical
    queue_arrival(64'd20000);     // high
    queue_arrival(64'd70000);     // medium
    queue_arrival(64'd570000);    // low
    queue_arrival(64'd2570000);   // under threshold_low, no beat
    queue_arrival(64'd2571000);   // elapsed exactly the interval
    queue_arrival(64'd2571999);   // one short of the interval
    queue_arrival(64'd2572000);   // two packets in the interval
    queue_arrival(64'd5);         // earlier than last check: huge elapsed
    queue_arrival('1);            // largest timestamp
    queue_arrival(64'd999);       // wraps forward by exactly the interval
    wait_idle();

    // Zero interval acts as one; threshold_low of zero passes everything,
    // critical at the top of its range. Spare indexes must not disturb.
    write_reg(pbrd_pkg::REG_INTERVAL, '0);
    write_reg(pbrd_pkg::REG_THR_LOW,  36'h0_0000_0000);
    write_reg(pbrd_pkg::REG_THR_MED,  36'd1000000000);
    write_reg(pbrd_pkg::REG_THR_HIGH, 36'hF_7735_9400);   // 2e9 with junk on top
    write_reg(pbrd_pkg::REG_THR_CRIT, 36'h0_FFFF_FFFF);
    for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++) begin
      idx = 3'(i);
      write_reg(idx, '1);
    end
    end_writes();
    t0 = 64'h0000_0001_0000_0000;
    queue_arrival(t0);             // closes with a huge elapsed, rate 0, severity 0
    queue_arrival(t0);             // same time, no check
    queue_arrival(t0);
    queue_arrival(t0 + 1);         // three packets in 1 ns: high
    queue_arrival(t0 + 2);         // medium
    queue_arrival(t0 + 4);         // low
    for (int i = 0; i < 4; i++) queue_arrival(t0 + 4);
    queue_arrival(t0 + 5);         // five packets in 1 ns: critical
    wait_idle();

    // Largest interval with thresholds at the extremes.
    write_reg(pbrd_pkg::REG_INTERVAL, 36'hF_FFFF_FFFF);
    write_reg(pbrd_pkg::REG_THR_LOW,  36'd0);
    write_reg(pbrd_pkg::REG_THR_MED,  36'd1);
    write_reg(pbrd_pkg::REG_THR_HIGH, 36'd2);
    write_reg(pbrd_pkg::REG_THR_CRIT, 36'h0_FFFF_FFFF);
    end_writes();
    queue_arrival(t0 + 64'hF_FFFF_FFFF);
    queue_arrival(t0 + 64'h1F_FFFF_FFFE + 5);
    wait_idle();

    next_ts = t0;
    while (items_queued < RANDOM_ITEMS + 30)
      random_phase($urandom_range(20, 60));

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
